@@ src/mwvd_pkg.sv @@
// Package with the widths, control types, state codes and helpers of the dispersion block.
package mwvd_pkg;

  localparam int VEL_W   = 16;
  localparam int MASS_W  = 16;
  localparam int MAG_W   = 17;
  localparam int SQ_W    = 34;
  localparam int SPD_W   = 32;
  localparam int DSQ_W   = 34;
  localparam int SSUM_W  = 33;
  localparam int QDIG_W  = 17;
  localparam int EPRD_W  = 48;
  localparam int DPRD_W  = 50;
  localparam int RPRD_W  = 33;
  localparam int ACC_W   = 63;
  localparam int CNT_W   = 5;
  localparam int SQ_STEPS  = 17;
  localparam int DIV_STEPS = 17;

  localparam logic [ACC_W-1:0] SAT63 = {ACC_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_DIVIDE,
    ST_ACCUM
  } mwvd_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } mwvd_ctrl_t;

  typedef struct packed {
    logic [EPRD_W-1:0] e1;
    logic [EPRD_W-1:0] e2;
    logic [DPRD_W-1:0] disp;
    logic [RPRD_W-1:0] rate;
    logic              ssum_zero;
  } mwvd_terms_t;

  // Adds a term to an accumulator and clamps at the largest 63-bit value.
  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc,
                                               logic [DPRD_W-1:0] term);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + {{(ACC_W + 1 - DPRD_W){1'b0}}, term};
    return s[ACC_W] ? SAT63 : s[ACC_W-1:0];
  endfunction

endpackage

@@ src/mwvd_if.sv @@
// Interfaces for the body input channel and the result output channel.
interface mwvd_body_if import mwvd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MASS_W-1:0]        mass_first;
  logic [MASS_W-1:0]        mass_second;
  logic signed [VEL_W-1:0]  vx_first;
  logic signed [VEL_W-1:0]  vy_first;
  logic signed [VEL_W-1:0]  vz_first;
  logic signed [VEL_W-1:0]  vx_second;
  logic signed [VEL_W-1:0]  vy_second;
  logic signed [VEL_W-1:0]  vz_second;
  logic                     last_body;

  modport source (
    output valid, mass_first, mass_second, vx_first, vy_first, vz_first,
           vx_second, vy_second, vz_second, last_body,
    input  ready
  );
  modport sink (
    input  valid, mass_first, mass_second, vx_first, vy_first, vz_first,
           vx_second, vy_second, vz_second, last_body,
    output ready
  );
endinterface

interface mwvd_result_if import mwvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] energy_first;
  logic [ACC_W-1:0] energy_second;
  logic [ACC_W-1:0] dispersion_sum;
  logic [ACC_W-1:0] rate_sum;

  modport source (
    output valid, energy_first, energy_second, dispersion_sum, rate_sum,
    input  ready
  );
  modport sink (
    input  valid, energy_first, energy_second, dispersion_sum, rate_sum,
    output ready
  );
endinterface

@@ src/mass_weighted_velocity_dispersion_top.sv @@
// Top level of the mass-weighted velocity dispersion accumulator.
//
// The body channel carries one word per body: both masses, both velocity
// vectors and a flag that marks the last body of a set. The result channel
// carries one word per set: the four saturating sums, with every body of the
// set included. A body word without the flag produces no result word.
//
// A body is accepted only while the block is idle. After acceptance the nine
// squares run bit-serially, a sum state forms the speed sums, and a radix-2
// divider produces the 17 quotient bits of the rate term while the mass
// products run alongside it, one mass bit per cycle. A final accumulate state
// adds the terms into the accumulators. A body keeps the block busy through
// the squaring and divider loops and the accumulate state, and ready returns
// only after that; the result word is loaded into the output register in the
// accumulate state of the last body.
//
// The result sits in an output register, so the next set can start while a
// result waits. If the receiver still stalls when the next last body reaches
// its accumulate cycle, the block holds there until the register frees.
// Synchronous reset clears the accumulators, the controller and the output valid flag.
module mass_weighted_velocity_dispersion_top import mwvd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mwvd_body_if.sink     body,
  mwvd_result_if.source result
);

  mwvd_state_t        state, state_next;
  logic [CNT_W-1:0]   cnt;
  logic [MASS_W-1:0]  mass1;
  logic [MASS_W-1:0]  mass2;
  logic               last_item;

  logic [ACC_W-1:0]   acc_energy_first;
  logic [ACC_W-1:0]   acc_energy_second;
  logic [ACC_W-1:0]   acc_dispersion;
  logic [ACC_W-1:0]   acc_rate;

  logic               out_valid;
  logic [ACC_W-1:0]   out_e1, out_e2, out_disp, out_rate;

  mwvd_ctrl_t         sq_ctrl, dv_ctrl;
  logic               in_ready;
  logic               commit;
  logic               out_free;
  logic               accept;

  logic [SPD_W-1:0]   s1, s2;
  logic [DSQ_W-1:0]   dsq;
  mwvd_terms_t        terms;

  logic [ACC_W-1:0]   sum_e1, sum_e2, sum_disp, sum_rate;

  assign accept   = body.valid && in_ready;
  assign out_free = !last_item || !out_valid || result.ready;

  mwvd_sq_lanes u_sq (
    .clk       (clk),
    .ctrl      (sq_ctrl),
    .vx_first  (body.vx_first),
    .vy_first  (body.vy_first),
    .vz_first  (body.vz_first),
    .vx_second (body.vx_second),
    .vy_second (body.vy_second),
    .vz_second (body.vz_second),
    .s1        (s1),
    .s2        (s2),
    .d         (dsq)
  );

  mwvd_div_mac u_div (
    .clk   (clk),
    .ctrl  (dv_ctrl),
    .s1    (s1),
    .s2    (s2),
    .d     (dsq),
    .m1    (mass1),
    .m2    (mass2),
    .terms (terms)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (body.valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (cnt == CNT_W'(SQ_STEPS - 1)) state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready     = 1'b0;
    sq_ctrl      = '0;
    dv_ctrl      = '0;
    commit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        sq_ctrl.load = body.valid;
      end
      ST_SQUARE: sq_ctrl.step = 1'b1;
      ST_SUM:    dv_ctrl.load = 1'b1;
      ST_DIVIDE: dv_ctrl.step = 1'b1;
      ST_ACCUM:  commit       = out_free;
      default: ;
    endcase
  end

  assign body.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SQUARE || state == ST_DIVIDE) begin
        cnt <= (state_next == state) ? cnt + 1'b1 : '0;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mass1     <= body.mass_first;
      mass2     <= body.mass_second;
      last_item <= body.last_body;
    end
  end

  // The rate term is skipped when both squared speeds are zero.
  always_comb begin
    sum_e1   = sat_add(acc_energy_first,  {{(DPRD_W-EPRD_W){1'b0}}, terms.e1});
    sum_e2   = sat_add(acc_energy_second, {{(DPRD_W-EPRD_W){1'b0}}, terms.e2});
    sum_disp = sat_add(acc_dispersion,    terms.disp);
    sum_rate = terms.ssum_zero ? acc_rate
             : sat_add(acc_rate, {{(DPRD_W-RPRD_W){1'b0}}, terms.rate});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_energy_first  <= '0;
      acc_energy_second <= '0;
      acc_dispersion    <= '0;
      acc_rate          <= '0;
    end else if (commit) begin
      if (last_item) begin
        acc_energy_first  <= '0;
        acc_energy_second <= '0;
        acc_dispersion    <= '0;
        acc_rate          <= '0;
      end else begin
        acc_energy_first  <= sum_e1;
        acc_energy_second <= sum_e2;
        acc_dispersion    <= sum_disp;
        acc_rate          <= sum_rate;
      end
    end
  end

  // Output register: loaded on the last body of a set, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && last_item) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && last_item) begin
      out_e1   <= sum_e1;
      out_e2   <= sum_e2;
      out_disp <= sum_disp;
      out_rate <= sum_rate;
    end
  end

  assign result.valid          = out_valid;
  assign result.energy_first   = out_e1;
  assign result.energy_second  = out_e2;
  assign result.dispersion_sum = out_disp;
  assign result.rate_sum       = out_rate;

`ifndef SYNTHESIS
  // Half the squared change never exceeds the speed sum, so the rate
  // product is bounded by the mass times one.
  a_rate_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM && !terms.ssum_zero) |->
      (terms.rate <= {1'b0, mass1, {MASS_W{1'b0}}}))
    else $error("rate product exceeds mass bound");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (commit && last_item) |=>
      (acc_energy_first == '0 && acc_energy_second == '0 &&
       acc_dispersion == '0 && acc_rate == '0))
    else $error("accumulators not cleared after last body");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_ACCUM))
    else $error("result raised outside accumulate cycle");

  a_start_square: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SQUARE && cnt == '0))
    else $error("squaring did not start after acceptance");
`endif

endmodule

@@ src/mwvd_sq_lanes.sv @@
// Nine bit-serial squaring lanes for both speeds and the velocity change.
module mwvd_sq_lanes import mwvd_pkg::*; (
  input  logic                    clk,
  input  mwvd_ctrl_t              ctrl,
  input  logic signed [VEL_W-1:0] vx_first,
  input  logic signed [VEL_W-1:0] vy_first,
  input  logic signed [VEL_W-1:0] vz_first,
  input  logic signed [VEL_W-1:0] vx_second,
  input  logic signed [VEL_W-1:0] vy_second,
  input  logic signed [VEL_W-1:0] vz_second,
  output logic [SPD_W-1:0]        s1,
  output logic [SPD_W-1:0]        s2,
  output logic [DSQ_W-1:0]        d
);

  localparam int LANES = 9;

  logic signed [MAG_W-1:0] sv [LANES];
  logic [MAG_W-1:0]        mag_in [LANES];
  logic [MAG_W-1:0]        mag [LANES];
  logic [MAG_W-1:0]        msh [LANES];
  logic [SQ_W-1:0]         prod [LANES];
  logic [SQ_W-1:0]         sum_a, sum_b, sum_d;

  always_comb begin
    sv[0] = MAG_W'(vx_first);
    sv[1] = MAG_W'(vy_first);
    sv[2] = MAG_W'(vz_first);
    sv[3] = MAG_W'(vx_second);
    sv[4] = MAG_W'(vy_second);
    sv[5] = MAG_W'(vz_second);
    sv[6] = MAG_W'(vx_second) - MAG_W'(vx_first);
    sv[7] = MAG_W'(vy_second) - MAG_W'(vy_first);
    sv[8] = MAG_W'(vz_second) - MAG_W'(vz_first);
    for (int i = 0; i < LANES; i++) begin
      // A 17-bit magnitude holds even the most negative difference.
      mag_in[i] = sv[i][MAG_W-1] ? MAG_W'(-sv[i]) : MAG_W'(sv[i]);
    end
  end

  // Each lane squares its magnitude, multiplier bits taken MSB first.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (ctrl.load) begin
        mag[i]  <= mag_in[i];
        msh[i]  <= mag_in[i];
        prod[i] <= '0;
      end else if (ctrl.step) begin
        prod[i] <= {prod[i][SQ_W-2:0], 1'b0}
                   + (msh[i][MAG_W-1] ? {{(SQ_W-MAG_W){1'b0}}, mag[i]} : '0);
        msh[i]  <= {msh[i][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sum_a = prod[0] + prod[1] + prod[2];
    sum_b = prod[3] + prod[4] + prod[5];
    sum_d = prod[6] + prod[7] + prod[8];
    s1 = sum_a[SPD_W-1:0];
    s2 = sum_b[SPD_W-1:0];
    d  = sum_d;
  end

endmodule

@@ src/mwvd_div_mac.sv @@
// Radix-2 divider for the rate quotient and bit-serial mass multipliers.
module mwvd_div_mac import mwvd_pkg::*; (
  input  logic              clk,
  input  mwvd_ctrl_t        ctrl,
  input  logic [SPD_W-1:0]  s1,
  input  logic [SPD_W-1:0]  s2,
  input  logic [DSQ_W-1:0]  d,
  input  logic [MASS_W-1:0] m1,
  input  logic [MASS_W-1:0] m2,
  output mwvd_terms_t       terms
);

  logic [SSUM_W-1:0] ssum;
  logic [SSUM_W-1:0] rem;
  logic [QDIG_W-1:0] nsh;
  logic [QDIG_W-1:0] m1sh;
  logic [QDIG_W-1:0] m2sh;
  logic [SPD_W-1:0]  s1r;
  logic [SPD_W-1:0]  s2r;
  logic [DSQ_W-1:0]  dr;
  logic [MASS_W-1:0] m1r;
  logic [EPRD_W-1:0] p_e1;
  logic [EPRD_W-1:0] p_e2;
  logic [DPRD_W-1:0] p_d;
  logic [RPRD_W-1:0] p_r;
  logic              zero;

  logic [SSUM_W:0]   trial;
  logic [SSUM_W:0]   diff;
  logic              qbit;
  logic [SSUM_W-1:0] rem_next;

  // The numerator is d shifted up by 15. Its upper part, d over 4, is
  // always below the divisor, so 17 quotient bits remain to be found.
  always_comb begin
    trial    = {rem, nsh[QDIG_W-1]};
    diff     = trial - {1'b0, ssum};
    qbit     = (trial >= {1'b0, ssum});
    rem_next = qbit ? diff[SSUM_W-1:0] : trial[SSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ssum <= {1'b0, s1} + {1'b0, s2};
      zero <= (s1 == '0) && (s2 == '0);
      rem  <= SSUM_W'(d[DSQ_W-1:2]);
      nsh  <= {d[1:0], {(QDIG_W-2){1'b0}}};
      m1sh <= {1'b0, m1};
      m2sh <= {1'b0, m2};
      s1r  <= s1;
      s2r  <= s2;
      dr   <= d;
      m1r  <= m1;
      p_e1 <= '0;
      p_e2 <= '0;
      p_d  <= '0;
      p_r  <= '0;
    end else if (ctrl.step) begin
      rem  <= rem_next;
      nsh  <= {nsh[QDIG_W-2:0], 1'b0};
      m1sh <= {m1sh[QDIG_W-2:0], 1'b0};
      m2sh <= {m2sh[QDIG_W-2:0], 1'b0};
      p_e1 <= {p_e1[EPRD_W-2:0], 1'b0}
              + (m1sh[QDIG_W-1] ? {{(EPRD_W-SPD_W){1'b0}}, s1r} : '0);
      p_e2 <= {p_e2[EPRD_W-2:0], 1'b0}
              + (m2sh[QDIG_W-1] ? {{(EPRD_W-SPD_W){1'b0}}, s2r} : '0);
      p_d  <= {p_d[DPRD_W-2:0], 1'b0}
              + (m1sh[QDIG_W-1] ? {{(DPRD_W-DSQ_W){1'b0}}, dr} : '0);
      // Quotient bits come out MSB first and feed the rate product at once.
      p_r  <= {p_r[RPRD_W-2:0], 1'b0}
              + (qbit ? {{(RPRD_W-MASS_W){1'b0}}, m1r} : '0);
    end
  end

  always_comb begin
    terms.e1        = p_e1;
    terms.e2        = p_e2;
    terms.disp      = p_d;
    terms.rate      = p_r;
    terms.ssum_zero = zero;
  end

endmodule

@@ test/mass_weighted_velocity_dispersion_top_tb.sv @@
// Self-checking testbench for the mass-weighted velocity dispersion accumulator.
`timescale 1ns / 1ps

typedef struct packed {
  logic [mwvd_pkg::MASS_W-1:0]       mass_first;
  logic [mwvd_pkg::MASS_W-1:0]       mass_second;
  logic signed [mwvd_pkg::VEL_W-1:0] vx_first;
  logic signed [mwvd_pkg::VEL_W-1:0] vy_first;
  logic signed [mwvd_pkg::VEL_W-1:0] vz_first;
  logic signed [mwvd_pkg::VEL_W-1:0] vx_second;
  logic signed [mwvd_pkg::VEL_W-1:0] vy_second;
  logic signed [mwvd_pkg::VEL_W-1:0] vz_second;
  logic                              last_body;
} body_word_t;

typedef struct packed {
  logic [mwvd_pkg::ACC_W-1:0] energy_first;
  logic [mwvd_pkg::ACC_W-1:0] energy_second;
  logic [mwvd_pkg::ACC_W-1:0] dispersion_sum;
  logic [mwvd_pkg::ACC_W-1:0] rate_sum;
} set_sums_t;

// Keeps running sums per set and compares each result word with the oldest finished set.
class dispersion_scoreboard;
  logic [mwvd_pkg::ACC_W-1:0] run_energy_first;
  logic [mwvd_pkg::ACC_W-1:0] run_energy_second;
  logic [mwvd_pkg::ACC_W-1:0] run_dispersion;
  logic [mwvd_pkg::ACC_W-1:0] run_rate;
  set_sums_t                  finished_sets[$];
  int                         mismatches;

  function new();
    mismatches = 0;
    clear_sums();
  endfunction

  function void clear_sums();
    run_energy_first  = '0;
    run_energy_second = '0;
    run_dispersion    = '0;
    run_rate          = '0;
  endfunction

  // Adds a term and clamps at the top of the 63-bit range.
  function logic [mwvd_pkg::ACC_W-1:0] clamp_add(logic [mwvd_pkg::ACC_W-1:0] sum,
                                                 logic [63:0] term);
    logic [63:0] total;
    total = {1'b0, sum} + term;
    return total[63] ? {mwvd_pkg::ACC_W{1'b1}} : total[mwvd_pkg::ACC_W-1:0];
  endfunction

  function void note_body(body_word_t b);
    longint      ax, ay, az, bx, by, bz;
    logic [63:0] spd_first, spd_second, change, spd_total, half_ratio, m1, m2;
    ax = longint'($signed(b.vx_first));
    ay = longint'($signed(b.vy_first));
    az = longint'($signed(b.vz_first));
    bx = longint'($signed(b.vx_second));
    by = longint'($signed(b.vy_second));
    bz = longint'($signed(b.vz_second));
    m1 = 64'(b.mass_first);
    m2 = 64'(b.mass_second);
    spd_first  = 64'(ax * ax + ay * ay + az * az);
    spd_second = 64'(bx * bx + by * by + bz * bz);
    change     = 64'((bx - ax) * (bx - ax) + (by - ay) * (by - ay) + (bz - az) * (bz - az));
    spd_total  = spd_first + spd_second;
    run_energy_first  = clamp_add(run_energy_first, m1 * spd_first);
    run_energy_second = clamp_add(run_energy_second, m2 * spd_second);
    run_dispersion    = clamp_add(run_dispersion, m1 * change);
    if (spd_total != 0) begin
      half_ratio = (change << 15) / spd_total;
      run_rate   = clamp_add(run_rate, m1 * half_ratio);
    end
    if (b.last_body) begin
      finished_sets.push_back({run_energy_first, run_energy_second, run_dispersion, run_rate});
      clear_sums();
    end
  endfunction

  function void compare_field(string name, logic [mwvd_pkg::ACC_W-1:0] want,
                              logic [mwvd_pkg::ACC_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(set_sums_t got);
    set_sums_t want;
    if (finished_sets.size() == 0) begin
      mismatches++;
      $display("%0t ns: unexpected result word, actual %h %h %h %h", $time,
               got.energy_first, got.energy_second, got.dispersion_sum, got.rate_sum);
      return;
    end
    want = finished_sets.pop_front();
    compare_field("energy_first", want.energy_first, got.energy_first);
    compare_field("energy_second", want.energy_second, got.energy_second);
    compare_field("dispersion_sum", want.dispersion_sum, got.dispersion_sum);
    compare_field("rate_sum", want.rate_sum, got.rate_sum);
  endfunction
endclass

module mass_weighted_velocity_dispersion_top_tb;
  import mwvd_pkg::*;

  // Time a body takes inside the block; the closing wait covers that with margin.
  localparam int BODY_CYCLES = 37;
  localparam int PHASE_ITEMS = 570;
  // Length of one long set of bodies with full first mass and every component
  // swinging across the full range, which builds the largest first-energy and dispersion terms per body.
  localparam int LONG_BODIES = 60;

  logic clk;
  logic rst;

  mwvd_body_if   body_ch();
  mwvd_result_if result_ch();

  mass_weighted_velocity_dispersion_top u_top (
    .clk    (clk),
    .rst    (rst),
    .body   (body_ch),
    .result (result_ch)
  );

  dispersion_scoreboard sums_sb;

  // Percent of cycles in which the sender or the receiver holds back.
  int sender_idle_pct;
  int receiver_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, so only a hang can trip it.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver changes its mind each falling edge according to the current idle rate.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Result words are sampled on the rising edge, where the handshake completes.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sums_sb.check_result({result_ch.energy_first, result_ch.energy_second,
                            result_ch.dispersion_sum, result_ch.rate_sum});
    end
  end

  function automatic body_word_t make_body(int m1, int m2, int ax, int ay, int az,
                                           int bx, int by, int bz, bit last);
    body_word_t b;
    b.mass_first  = MASS_W'(m1);
    b.mass_second = MASS_W'(m2);
    b.vx_first    = VEL_W'(ax);
    b.vy_first    = VEL_W'(ay);
    b.vz_first    = VEL_W'(az);
    b.vx_second   = VEL_W'(bx);
    b.vy_second   = VEL_W'(by);
    b.vz_second   = VEL_W'(bz);
    b.last_body   = last;
    return b;
  endfunction

  // One velocity component; the style picks zero, full range, small or an extreme.
  function automatic int pick_velocity(int style);
    int v;
    case (style)
      0: v = 0;
      1: v = $urandom_range(65535) - 32768;
      2: v = $urandom_range(1023) - 512;
      default: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int pick_mass();
    int m;
    case ($urandom_range(9))
      0: m = 0;
      1: m = 65535;
      2: m = $urandom_range(255);
      default: m = $urandom_range(65535);
    endcase
    return m;
  endfunction

  function automatic body_word_t random_body(bit last);
    int sa, sb, ax, ay, az, bx, by, bz;
    sa = $urandom_range(9);
    sb = $urandom_range(9);
    // Zero vectors stay common so that both speeds vanish now and then and the
    // rate term gets skipped.
    sa = (sa == 0) ? 0 : (sa < 6) ? 1 : (sa < 8) ? 2 : 3;
    ax = pick_velocity(sa);
    ay = pick_velocity(sa);
    az = pick_velocity(sa);
    if (sb == 9) begin
      // Unchanged velocity: no dispersion from this body.
      bx = ax;
      by = ay;
      bz = az;
    end else begin
      sb = (sb == 0) ? 0 : (sb < 6) ? 1 : (sb < 8) ? 2 : 3;
      bx = pick_velocity(sb);
      by = pick_velocity(sb);
      bz = pick_velocity(sb);
    end
    return make_body(pick_mass(), pick_mass(), ax, ay, az, bx, by, bz, last);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_body(body_word_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      body_ch.valid <= 1'b0;
      @(negedge clk);
    end
    body_ch.valid       <= 1'b1;
    body_ch.mass_first  <= b.mass_first;
    body_ch.mass_second <= b.mass_second;
    body_ch.vx_first    <= b.vx_first;
    body_ch.vy_first    <= b.vy_first;
    body_ch.vz_first    <= b.vz_first;
    body_ch.vx_second   <= b.vx_second;
    body_ch.vy_second   <= b.vy_second;
    body_ch.vz_second   <= b.vz_second;
    body_ch.last_body   <= b.last_body;
    do @(posedge clk); while (!body_ch.ready);
    sums_sb.note_body(b);
    @(negedge clk);
  endtask

  // Holds the sender back until every finished set has come out.
  task automatic wait_for_results();
    body_ch.valid <= 1'b0;
    @(negedge clk);
    while (sums_sb.finished_sets.size() != 0) @(negedge clk);
  endtask

  // Random sets, mostly short, now and then long; the sender sometimes waits
  // for the results to drain after closing a set.
  task automatic random_phase(int items);
    int sent, set_len;
    sent = 0;
    while (sent < items) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(6, 1);
      for (int i = 0; i < set_len; i++) begin
        send_body(random_body(i == set_len - 1));
      end
      sent += set_len;
      if ($urandom_range(19) == 0) wait_for_results();
    end
  endtask

  initial begin
    sums_sb = new();
    sender_idle_pct   = 6;
    receiver_idle_pct = 63;

    rst                   = 1'b1;
    body_ch.valid         = 1'b0;
    body_ch.mass_first    = '0;
    body_ch.mass_second   = '0;
    body_ch.vx_first      = '0;
    body_ch.vy_first      = '0;
    body_ch.vz_first      = '0;
    body_ch.vx_second     = '0;
    body_ch.vy_second     = '0;
    body_ch.vz_second     = '0;
    body_ch.last_body     = 1'b0;
    result_ch.ready       = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed bodies. A set of one resting body: both speeds are zero, so the
    // rate term is skipped and every sum is zero.
    send_body(make_body(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_body(make_body(65535, 65535, 0, 0, 0, 0, 0, 0, 1'b1));
    // Full masses with every component swinging from one extreme to the other.
    send_body(make_body(65535, 65535, -32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
    send_body(make_body(65535, 65535, 32767, -32768, 32767, -32768, 32767, -32768, 1'b1));
    // Unchanged velocities give zero dispersion and a zero rate term.
    send_body(make_body(65535, 1, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
    send_body(make_body(1, 65535, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
    // Massless bodies still take part in the second energy sum only through mass_second.
    send_body(make_body(0, 0, -32768, 32767, 0, 32767, -32768, 0, 1'b0));
    send_body(make_body(0, 65535, 1, -1, 1, -1, 1, -1, 1'b1));
    // Speed in only one snapshot: the change equals that speed.
    send_body(make_body(40000, 20000, 0, 0, 0, 256, -256, 128, 1'b0));
    send_body(make_body(40000, 20000, -300, 700, -1, 0, 0, 0, 1'b1));
    // Smallest nonzero velocity and mass.
    send_body(make_body(1, 1, 1, 0, 0, 0, 0, 1, 1'b1));
    // A single-axis body on each axis in turn, then mixed signs.
    send_body(make_body(32768, 32768, -32768, 0, 0, 0, 0, 0, 1'b0));
    send_body(make_body(32768, 32768, 0, 32767, 0, 0, -1, 0, 1'b0));
    send_body(make_body(32768, 32768, 0, 0, -32768, 0, 0, 32767, 1'b0));
    send_body(make_body(12345, 54321, 1000, -2000, 3000, -4000, 5000, -6000, 1'b1));
    wait_for_results();

    // Phase one: a stalling receiver against an eager sender.
    random_phase(PHASE_ITEMS);
    wait_for_results();

    // Phase two: the sender idles most of the time, the receiver rarely.
    sender_idle_pct   = 63;
    receiver_idle_pct = 6;
    random_phase(PHASE_ITEMS);
    wait_for_results();

    // Phase three: no idling on either side.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    random_phase(PHASE_ITEMS);

    // One long set of extreme bodies; the second velocity mirrors the first so
    // that each component swings across the full range.
    for (int i = 0; i < LONG_BODIES; i++) begin
      int ax, ay, az;
      ax = $urandom_range(1) ? -32768 : 32767;
      ay = $urandom_range(1) ? -32768 : 32767;
      az = $urandom_range(1) ? -32768 : 32767;
      send_body(make_body(65535, $urandom_range(65535), ax, ay, az, ~ax, ~ay, ~az, 1'b0));
    end
    send_body(make_body(65535, 65535, -32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    // The next set must start from cleared sums.
    send_body(random_body(1'b0));
    send_body(random_body(1'b1));

    body_ch.valid <= 1'b0;
    while (sums_sb.finished_sets.size() != 0) @(negedge clk);
    // Any stray word from a body still in flight would show up in this window.
    repeat (4 * BODY_CYCLES) @(negedge clk);

    if (sums_sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mwvd_pkg.sv
src/mwvd_if.sv
src/mwvd_sq_lanes.sv
src/mwvd_div_mac.sv
src/mass_weighted_velocity_dispersion_top.sv
test/mass_weighted_velocity_dispersion_top_tb.sv
